// ----- hdl/lc3ie_pkg.sv -----
package lc3ie_pkg;

  // item commands
  localparam logic [1:0] OP_STEP = 2'd0;
  localparam logic [1:0] OP_WMEM = 2'd1;
  localparam logic [1:0] OP_WREG = 2'd2;
  localparam logic [1:0] OP_SETPC = 2'd3;

  // result status codes
  localparam logic [1:0] ST_EXECUTED = 2'd0;
  localparam logic [1:0] ST_HALTED = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;
  localparam logic [1:0] ST_LOADED = 2'd3;

  // instruction opcodes
  localparam logic [3:0] OPC_BR = 4'h0;
  localparam logic [3:0] OPC_ADD = 4'h1;
  localparam logic [3:0] OPC_LD = 4'h2;
  localparam logic [3:0] OPC_ST = 4'h3;
  localparam logic [3:0] OPC_JSR = 4'h4;
  localparam logic [3:0] OPC_AND = 4'h5;
  localparam logic [3:0] OPC_LDR = 4'h6;
  localparam logic [3:0] OPC_STR = 4'h7;
  localparam logic [3:0] OPC_RTI = 4'h8;
  localparam logic [3:0] OPC_NOT = 4'h9;
  localparam logic [3:0] OPC_LDI = 4'hA;
  localparam logic [3:0] OPC_STI = 4'hB;
  localparam logic [3:0] OPC_JMP = 4'hC;
  localparam logic [3:0] OPC_RES = 4'hD;
  localparam logic [3:0] OPC_LEA = 4'hE;
  localparam logic [3:0] OPC_TRAP = 4'hF;

  // trap vectors
  localparam logic [7:0] TRAP_GETC = 8'h20;
  localparam logic [7:0] TRAP_OUT = 8'h21;
  localparam logic [7:0] TRAP_IN = 8'h23;
  localparam logic [7:0] TRAP_HALT = 8'h25;
  localparam logic [7:0] TRAP_X24 = 8'h24;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_DECODE,
    S_RDA,
    S_RDB,
    S_EXEC,
    S_IND_LD,
    S_IND_ST,
    S_LOAD_WB,
    S_TRAP_KEY,
    S_RESP
  } state_e;

  typedef struct packed {
    logic clr;
    logic load_op;
    logic fetch;
    logic latch_ir;
    logic rd_sr1;
    logic rd_sel2;
    logic exec;
    logic rd_ind;
    logic st_ind;
    logic wb_mem;
    logic trap_key;
  } cmd_t;

  typedef struct packed {
    logic [3:0] opcode;
    logic       trap_key;
    logic       running;
    logic       clr_last;
  } stat_t;

endpackage

// ----- hdl/lc3ie_ram.sv -----
module lc3ie_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hdl/lc3ie_ctrl.sv -----
module lc3ie_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [1:0]           op_i,
  input  lc3ie_pkg::stat_t     stat_i,
  output lc3ie_pkg::cmd_t      cmd_o,
  output logic                 busy_o,
  output logic                 done_o
);

  lc3ie_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lc3ie_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lc3ie_pkg::S_CLEAR: if (stat_i.clr_last) state_d = lc3ie_pkg::S_IDLE;
      lc3ie_pkg::S_IDLE: begin
        if (start_i) begin
          if (op_i == lc3ie_pkg::OP_STEP && stat_i.running) state_d = lc3ie_pkg::S_FETCH;
          else state_d = lc3ie_pkg::S_RESP;
        end
      end
      lc3ie_pkg::S_FETCH: state_d = lc3ie_pkg::S_DECODE;
      lc3ie_pkg::S_DECODE: state_d = lc3ie_pkg::S_RDA;
      lc3ie_pkg::S_RDA: state_d = lc3ie_pkg::S_RDB;
      lc3ie_pkg::S_RDB: state_d = lc3ie_pkg::S_EXEC;
      lc3ie_pkg::S_EXEC: begin
        unique case (stat_i.opcode) inside
          lc3ie_pkg::OPC_LD, lc3ie_pkg::OPC_LDR: state_d = lc3ie_pkg::S_LOAD_WB;
          lc3ie_pkg::OPC_LDI: state_d = lc3ie_pkg::S_IND_LD;
          lc3ie_pkg::OPC_STI: state_d = lc3ie_pkg::S_IND_ST;
          lc3ie_pkg::OPC_TRAP: begin
            state_d = stat_i.trap_key ? lc3ie_pkg::S_TRAP_KEY : lc3ie_pkg::S_RESP;
          end
          default: state_d = lc3ie_pkg::S_RESP;
        endcase
      end
      lc3ie_pkg::S_IND_LD: state_d = lc3ie_pkg::S_LOAD_WB;
      lc3ie_pkg::S_IND_ST: state_d = lc3ie_pkg::S_RESP;
      lc3ie_pkg::S_LOAD_WB: state_d = lc3ie_pkg::S_RESP;
      lc3ie_pkg::S_TRAP_KEY: state_d = lc3ie_pkg::S_RESP;
      lc3ie_pkg::S_RESP: state_d = lc3ie_pkg::S_IDLE;
      default: state_d = lc3ie_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy_o = 1'b1;
    done_o = 1'b0;
    unique case (state_q)
      lc3ie_pkg::S_CLEAR: cmd_o.clr = 1'b1;
      lc3ie_pkg::S_IDLE: begin
        busy_o = 1'b0;
        cmd_o.load_op = start_i;
      end
      lc3ie_pkg::S_FETCH: cmd_o.fetch = 1'b1;
      lc3ie_pkg::S_DECODE: cmd_o.latch_ir = 1'b1;
      lc3ie_pkg::S_RDA: cmd_o.rd_sr1 = 1'b1;
      lc3ie_pkg::S_RDB: cmd_o.rd_sel2 = 1'b1;
      lc3ie_pkg::S_EXEC: cmd_o.exec = 1'b1;
      lc3ie_pkg::S_IND_LD: cmd_o.rd_ind = 1'b1;
      lc3ie_pkg::S_IND_ST: cmd_o.st_ind = 1'b1;
      lc3ie_pkg::S_LOAD_WB: cmd_o.wb_mem = 1'b1;
      lc3ie_pkg::S_TRAP_KEY: cmd_o.trap_key = 1'b1;
      lc3ie_pkg::S_RESP: done_o = 1'b1;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ----- hdl/lc3ie_dp.sv -----
module lc3ie_dp #(
  parameter int MEM_WORDS = 65536
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lc3ie_pkg::cmd_t  cmd_i,
  output lc3ie_pkg::stat_t stat_o,
  input  logic [1:0]       op_i,
  input  logic [15:0]      address_i,
  input  logic [2:0]       reg_index_i,
  input  logic [15:0]      data_value_i,
  input  logic [7:0]       key_char_i,
  output logic [1:0]       status_o,
  output logic [15:0]      pc_after_o,
  output logic [15:0]      instr_word_o,
  output logic [2:0]       cond_flags_o,
  output logic [7:0]       out_char_o,
  output logic             out_char_valid_o,
  output logic             running_now_o
);

  localparam int AW = $clog2(MEM_WORDS);

  logic [15:0]   pc_q, pc_d, ir_q, ir_d, a_q, a_d, b_q, b_d;
  logic [2:0]    cc_q, cc_d;
  logic          run_q, run_d, ovalid_q, ovalid_d, rd_ok_q;
  logic [1:0]    status_q, status_d;
  logic [7:0]    och_q, och_d, key_q, key_d;
  logic [AW-1:0] cnt_q;

  logic [15:0]   mem_a, mem_wdata, mem_raw, mem_rd;
  logic          mem_we, in_range;
  logic [2:0]    rf_raddr, rf_waddr;
  logic [15:0]   rf_wdata, rf_rdata;
  logic          rf_we;

  logic [3:0]    opc;
  logic [2:0]    dr, sr1;
  logic [15:0]   off9, off11, off6, imm5, ea, opnd, res;
  logic          set_cc;

  assign opc   = ir_q[15:12];
  assign dr    = ir_q[11:9];
  assign sr1   = ir_q[8:6];
  assign off9  = {{7{ir_q[8]}}, ir_q[8:0]};
  assign off11 = {{5{ir_q[10]}}, ir_q[10:0]};
  assign off6  = {{10{ir_q[5]}}, ir_q[5:0]};
  assign imm5  = {{11{ir_q[4]}}, ir_q[4:0]};
  assign opnd  = ir_q[5] ? imm5 : rf_rdata;
  assign ea    = (opc == lc3ie_pkg::OPC_LDR || opc == lc3ie_pkg::OPC_STR) ?
                 a_q + off6 : pc_q + off9;

  assign mem_rd   = rd_ok_q ? mem_raw : 16'h0000;
  assign in_range = ({1'b0, mem_a} < 17'(MEM_WORDS));

  // memory address and write
  always_comb begin
    mem_a = pc_q;
    mem_wdata = rf_rdata;
    mem_we = 1'b0;
    if (cmd_i.load_op) begin
      mem_a = address_i;
      mem_wdata = data_value_i;
      mem_we = (op_i == lc3ie_pkg::OP_WMEM) && in_range;
    end else if (cmd_i.exec) begin
      mem_a = ea;
      mem_we = (opc == lc3ie_pkg::OPC_ST || opc == lc3ie_pkg::OPC_STR) && in_range;
    end else if (cmd_i.rd_ind || cmd_i.st_ind) begin
      mem_a = mem_rd;
      mem_wdata = b_q;
      mem_we = cmd_i.st_ind && in_range;
    end
  end

  lc3ie_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we || cmd_i.clr),
    .waddr_i (cmd_i.clr ? cnt_q : mem_a[AW-1:0]),
    .wdata_i (cmd_i.clr ? 16'h0000 : mem_wdata),
    .raddr_i (mem_a[AW-1:0]),
    .rdata_o (mem_raw)
  );

  // register file read select
  always_comb begin
    rf_raddr = sr1;
    if (cmd_i.rd_sr1 && opc == lc3ie_pkg::OPC_TRAP) begin
      rf_raddr = 3'd0;
    end else if (cmd_i.rd_sel2) begin
      rf_raddr = (opc == lc3ie_pkg::OPC_ST || opc == lc3ie_pkg::OPC_STR ||
                  opc == lc3ie_pkg::OPC_STI) ? dr : ir_q[2:0];
    end
  end

  // execute
  always_comb begin
    pc_d = pc_q;
    ir_d = ir_q;
    a_d = a_q;
    b_d = b_q;
    cc_d = cc_q;
    run_d = run_q;
    status_d = status_q;
    och_d = och_q;
    ovalid_d = ovalid_q;
    key_d = key_q;
    rf_we = 1'b0;
    rf_waddr = dr;
    rf_wdata = 16'h0000;
    res = 16'h0000;
    set_cc = 1'b0;
    if (cmd_i.clr) begin
      rf_we = (cnt_q[AW-1:3] == '0);
      rf_waddr = cnt_q[2:0];
    end
    if (cmd_i.load_op) begin
      ir_d = 16'h0000;
      och_d = 8'h00;
      ovalid_d = 1'b0;
      key_d = key_char_i;
      status_d = lc3ie_pkg::ST_LOADED;
      case (op_i)
        lc3ie_pkg::OP_STEP: begin
          status_d = run_q ? lc3ie_pkg::ST_EXECUTED : lc3ie_pkg::ST_IGNORED;
        end
        lc3ie_pkg::OP_WREG: begin
          rf_we = 1'b1;
          rf_waddr = reg_index_i;
          rf_wdata = data_value_i;
        end
        lc3ie_pkg::OP_SETPC: begin
          pc_d = address_i;
          run_d = 1'b1;
        end
        default: ;
      endcase
    end
    if (cmd_i.fetch) pc_d = pc_q + 16'd1;
    if (cmd_i.latch_ir) ir_d = mem_rd;
    if (cmd_i.rd_sel2) a_d = rf_rdata;
    if (cmd_i.exec) begin
      b_d = rf_rdata;
      unique case (opc) inside
        lc3ie_pkg::OPC_BR: if ((cc_q & dr) != 3'b000) pc_d = pc_q + off9;
        lc3ie_pkg::OPC_ADD: begin
          res = a_q + opnd;
          set_cc = 1'b1;
        end
        lc3ie_pkg::OPC_AND: begin
          res = a_q & opnd;
          set_cc = 1'b1;
        end
        lc3ie_pkg::OPC_NOT: begin
          res = ~a_q;
          set_cc = 1'b1;
        end
        lc3ie_pkg::OPC_LEA: begin
          res = pc_q + off9;
          set_cc = 1'b1;
        end
        lc3ie_pkg::OPC_JSR: begin
          rf_we = 1'b1;
          rf_waddr = 3'd7;
          rf_wdata = pc_q;
          pc_d = ir_q[11] ? pc_q + off11 : a_q;
        end
        lc3ie_pkg::OPC_JMP: pc_d = a_q;
        lc3ie_pkg::OPC_TRAP: begin
          rf_we = 1'b1;
          rf_waddr = 3'd7;
          rf_wdata = pc_q;
          if (ir_q[7:0] == lc3ie_pkg::TRAP_OUT) begin
            och_d = a_q[7:0];
            ovalid_d = 1'b1;
          end
          if (ir_q[7:0] == lc3ie_pkg::TRAP_HALT || ir_q[7:0] == lc3ie_pkg::TRAP_X24) begin
            run_d = 1'b0;
            status_d = lc3ie_pkg::ST_HALTED;
          end
        end
        lc3ie_pkg::OPC_RTI, lc3ie_pkg::OPC_RES: begin
          run_d = 1'b0;
          status_d = lc3ie_pkg::ST_HALTED;
        end
        default: ;
      endcase
    end
    if (cmd_i.wb_mem) begin
      res = mem_rd;
      set_cc = 1'b1;
    end
    if (set_cc) begin
      rf_we = 1'b1;
      rf_wdata = res;
      if (res == 16'h0000) cc_d = 3'b010;
      else if (res[15]) cc_d = 3'b100;
      else cc_d = 3'b001;
    end
    if (cmd_i.trap_key) begin
      rf_we = 1'b1;
      rf_waddr = 3'd0;
      rf_wdata = {8'h00, key_q};
    end
  end

  lc3ie_ram #(.WIDTH(16), .DEPTH(8)) u_rf (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .raddr_i (rf_raddr),
    .rdata_o (rf_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= 16'h0000;
      cc_q <= 3'b010;
      run_q <= 1'b1;
      cnt_q <= '0;
      rd_ok_q <= 1'b0;
      status_q <= lc3ie_pkg::ST_EXECUTED;
      ovalid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      cc_q <= cc_d;
      run_q <= run_d;
      rd_ok_q <= in_range;
      status_q <= status_d;
      ovalid_q <= ovalid_d;
      if (cmd_i.clr) cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    ir_q <= ir_d;
    a_q <= a_d;
    b_q <= b_d;
    och_q <= och_d;
    key_q <= key_d;
  end

  always_comb begin
    stat_o.opcode = opc;
    stat_o.trap_key = (ir_q[7:0] == lc3ie_pkg::TRAP_GETC) ||
                      (ir_q[7:0] == lc3ie_pkg::TRAP_IN);
    stat_o.running = run_q;
    stat_o.clr_last = (cnt_q == AW'(MEM_WORDS - 1));
  end

  assign status_o = status_q;
  assign pc_after_o = pc_q;
  assign instr_word_o = ir_q;
  assign cond_flags_o = cc_q;
  assign out_char_o = och_q;
  assign out_char_valid_o = ovalid_q;
  assign running_now_o = run_q;

endmodule

// ----- hdl/lc3_instruction_execute.sv -----
// Channel  | Handshake             | Ports
// ---------+-----------------------+-----------------------------------------------
// command  | start_i & !busy_o     | op_i address_i reg_index_i data_value_i key_char_i
// result   | done_o, one cycle     | status_o pc_after_o instr_word_o cond_flags_o
//          |                       | out_char_o out_char_valid_o running_now_o
//
// Loads and a step while halted: result in the cycle after accept. A step runs FETCH,
// DECODE, RDA, RDB, EXEC, RESP; LD/LDR add LOAD_WB, STI IND_ST, TRAP GETC/IN TRAP_KEY,
// LDI IND_LD and LOAD_WB: each memory access costs a registered read. busy_o stays high
// until the result is given. After reset the core clears all MEM_WORDS words and
// registers with busy_o high. The receiver cannot stall: done_o marks each word once.
module lc3_instruction_execute #(
  parameter int MEM_WORDS = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] address_i,
  input  logic [2:0]  reg_index_i,
  input  logic [15:0] data_value_i,
  input  logic [7:0]  key_char_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [15:0] pc_after_o,
  output logic [15:0] instr_word_o,
  output logic [2:0]  cond_flags_o,
  output logic [7:0]  out_char_o,
  output logic        out_char_valid_o,
  output logic        running_now_o
);

  // commands from sequencer, status back from datapath
  lc3ie_pkg::cmd_t  cmd;
  lc3ie_pkg::stat_t stat;

  lc3ie_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .op_i   (op_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o),
    .done_o (done_o)
  );

  // datapath: word memory, register file, PC, flags and result registers
  lc3ie_dp #(.MEM_WORDS(MEM_WORDS)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .op_i            (op_i),
    .address_i       (address_i),
    .reg_index_i     (reg_index_i),
    .data_value_i    (data_value_i),
    .key_char_i      (key_char_i),
    .status_o        (status_o),
    .pc_after_o      (pc_after_o),
    .instr_word_o    (instr_word_o),
    .cond_flags_o    (cond_flags_o),
    .out_char_o      (out_char_o),
    .out_char_valid_o(out_char_valid_o),
    .running_now_o   (running_now_o)
  );

endmodule
